// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_PROP(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/frua_pkg.sv
// ----------------------------------------------------------------------------
// frua_pkg
// Shared codes and control types of the frame ring upload allocator.
// ----------------------------------------------------------------------------
package frua_pkg;

    localparam logic [31:0] BUFFER_BYTES_RESET = 32'd1048576;
    localparam logic [1:0]  REQ_ALLOC          = 2'd0;
    localparam int          REQ_FRAME_END_BIT  = 1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_BIG  = 3'd1,
        ST_NO_GAP   = 3'd2,
        ST_OVL_PREV = 3'd3,
        ST_OVL_CUR  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH_X,
        OP_SUCC,
        OP_FIN,
        OP_FIN2,
        OP_GAP_DONE,
        OP_OVL
    } t_op;

    typedef struct packed {
        logic load;
        logic decide;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

// File: rtl/frua_if.sv
// ----------------------------------------------------------------------------
// frua_req_if / frua_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface frua_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] req_size;
    logic [4:0]  align_log2;

    modport source(output valid, output req_type, output req_size, output align_log2,
                   input ready);
    modport sink(input valid, input req_type, input req_size, input align_log2,
                 output ready);
endinterface

interface frua_rsp_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [2:0]  status;
    logic [31:0] offset;
    logic [31:0] largest_free;
    logic [31:0] largest_free_start;

    modport source(output valid, output success, output status, output offset,
                   output largest_free, output largest_free_start, input ready);
    modport sink(input valid, input success, input status, input offset,
                 input largest_free, input largest_free_start, output ready);
endinterface

// File: rtl/frua_datapath.sv
// ----------------------------------------------------------------------------
// frua_datapath
// Range tables, placement arithmetic, gap search and result register.
// ----------------------------------------------------------------------------
module frua_datapath #(
    parameter int MAX_RANGES     = 64,
    parameter int OFFSET_BITS    = 32,
    parameter int MIN_ALIGN_LOG2 = 5
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_wr_en,
    input  logic [31:0]                               i_cfg_wr_data,
    input  logic [1:0]                                i_req_type,
    input  logic [31:0]                               i_req_size,
    input  logic [4:0]                                i_align_log2,
    input  frua_pkg::t_cmd                            i_cmd,
    input  logic [$clog2(2*MAX_RANGES+1)-1:0]         i_idx,
    output logic [$clog2(2*MAX_RANGES+1)-1:0]         o_count,
    output frua_pkg::t_stat                           o_stat,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic                                      o_success,
    output logic [2:0]                                o_status,
    output logic [31:0]                               o_offset,
    output logic [31:0]                               o_largest_free,
    output logic [31:0]                               o_largest_free_start
);
    import frua_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int NW = $clog2(2 * MAX_RANGES + 1);
    localparam int OB = OFFSET_BITS;
    localparam int EW = 2 * OFFSET_BITS;

    logic [31:0]   r_buf;
    logic [OB-1:0] r_wo;
    logic [CW-1:0] r_cur_cnt, r_prev_cnt;
    logic          r_cur_bank;
    logic          r_out_valid;
    t_op           r_op_d;

    logic [1:0]    r_type;
    logic [31:0]   r_size;
    logic [4:0]    r_al;
    logic [EW-1:0] mem0 [MAX_RANGES];
    logic [EW-1:0] mem1 [MAX_RANGES];
    logic [EW-1:0] r_rd0, r_rd1;
    logic          r_prev_d;
    logic [EW-1:0] r_x, r_succ, r_min, r_best_key;
    logic          r_has_succ, r_have_min, r_have_best;
    logic [OB-1:0] r_g, r_gs, r_best, r_best_start, r_gsize, r_gstart;
    logic          r_ovp, r_ovc;
    logic [32:0]   r_wp, r_pad;
    logic [33:0]   r_aligned;
    logic [34:0]   r_place_end;
    logic [OB-1:0] r_b, r_e;
    logic          r_success;
    t_status       r_status;
    logic [31:0]   r_offset, r_lf, r_lfs;

    logic [OB-1:0] total;
    logic [4:0]    al_eff;
    logic [32:0]   amask;
    logic          fit_end;
    logic [OB-1:0] place_b;
    logic          is_prev;
    logic [NW-1:0] cur_off;
    logic [AW-1:0] prev_addr, cur_addr, addr0, addr1, wr_addr;
    logic [EW-1:0] rdata;
    logic [OB-1:0] nxt, xe, g_val;
    logic          hit;
    logic          frame_end, alloc, wr_en;
    t_status       st;

    always_comb begin
        total     = r_buf[OB-1:0];
        al_eff    = (i_align_log2 < 5'(MIN_ALIGN_LOG2)) ? 5'(MIN_ALIGN_LOG2) : i_align_log2;
        amask     = (33'd1 << r_al) - 33'd1;
        fit_end   = r_place_end < 35'(total);
        place_b   = fit_end ? r_wp[OB-1:0] : '0;
        is_prev   = i_idx < NW'(r_prev_cnt);
        cur_off   = i_idx - NW'(r_prev_cnt);
        prev_addr = i_idx[AW-1:0];
        cur_addr  = cur_off[AW-1:0];
        addr0     = r_cur_bank ? prev_addr : cur_addr;
        addr1     = r_cur_bank ? cur_addr : prev_addr;
        wr_addr   = r_cur_cnt[AW-1:0];
        if (r_prev_d) begin
            rdata = r_cur_bank ? r_rd0 : r_rd1;
        end else begin
            rdata = r_cur_bank ? r_rd1 : r_rd0;
        end
        nxt   = r_has_succ ? r_succ[EW-1:OB] : total;
        xe    = r_x[OB-1:0];
        g_val = (nxt > xe) ? nxt - xe : '0;
        hit   = (r_b < rdata[OB-1:0]) && (rdata[EW-1:OB] < r_e);
        frame_end = r_type[REQ_FRAME_END_BIT];
        alloc     = r_type == REQ_ALLOC;
        priority if (frame_end) begin
            st = ST_OK;
        end else if (r_aligned > 34'(total)) begin
            st = ST_TOO_BIG;
        end else if (r_aligned > 34'(r_gsize)) begin
            st = ST_NO_GAP;
        end else if (!fit_end && !(r_size < 32'(total))) begin
            st = ST_TOO_BIG;
        end else if (r_ovp) begin
            st = ST_OVL_PREV;
        end else if (r_ovc) begin
            st = ST_OVL_CUR;
        end else if (alloc && (r_cur_cnt >= CW'(MAX_RANGES))) begin
            st = ST_FULL;
        end else begin
            st = ST_OK;
        end
        wr_en = i_cmd.decide && !frame_end && (st == ST_OK) && alloc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= BUFFER_BYTES_RESET;
            r_wo        <= '0;
            r_cur_cnt   <= '0;
            r_prev_cnt  <= '0;
            r_cur_bank  <= 1'b0;
            r_out_valid <= 1'b0;
            r_op_d      <= OP_NONE;
        end else begin
            r_op_d <= i_cmd.op;
            if (i_cfg_wr_en) begin
                r_buf <= i_cfg_wr_data;
            end
            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
                if (frame_end) begin
                    r_cur_bank <= ~r_cur_bank;
                    r_prev_cnt <= r_cur_cnt;
                    r_cur_cnt  <= '0;
                end else if (wr_en) begin
                    r_cur_cnt <= r_cur_cnt + CW'(1);
                    r_wo      <= r_e;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd0 <= mem0[addr0];
        if (wr_en && !r_cur_bank) begin
            mem0[wr_addr] <= {r_b, r_e};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd1 <= mem1[addr1];
        if (wr_en && r_cur_bank) begin
            mem1[wr_addr] <= {r_b, r_e};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_d    <= is_prev;
        r_wp        <= (33'(r_wo) + amask) & ~amask;
        r_pad       <= r_wp - 33'(r_wo);
        r_aligned   <= {2'b00, r_size} + {1'b0, r_pad};
        r_place_end <= 35'(r_wo) + {1'b0, r_aligned};
        r_b         <= place_b;
        r_e         <= place_b + r_size[OB-1:0];
        if (i_cmd.load) begin
            r_type      <= i_req_type;
            r_size      <= i_req_size;
            r_al        <= al_eff;
            r_have_min  <= 1'b0;
            r_have_best <= 1'b0;
            r_ovp       <= 1'b0;
            r_ovc       <= 1'b0;
        end
        unique case (r_op_d)
            OP_LATCH_X: begin
                r_x        <= rdata;
                r_has_succ <= 1'b0;
                r_have_min <= 1'b1;
                if (!r_have_min || (rdata < r_min)) begin
                    r_min <= rdata;
                end
            end
            OP_SUCC: begin
                if ((rdata > r_x) && (!r_has_succ || (rdata < r_succ))) begin
                    r_succ     <= rdata;
                    r_has_succ <= 1'b1;
                end
            end
            OP_FIN: begin
                r_g  <= g_val;
                r_gs <= xe;
            end
            OP_FIN2: begin
                if (!r_have_best || (r_g > r_best) ||
                    ((r_g == r_best) && (r_x < r_best_key))) begin
                    r_best       <= r_g;
                    r_best_start <= r_gs;
                    r_best_key   <= r_x;
                    r_have_best  <= 1'b1;
                end
            end
            OP_GAP_DONE: begin
                if (!r_have_min) begin
                    r_gsize  <= total;
                    r_gstart <= '0;
                end else if (r_have_best && (r_best > r_min[EW-1:OB])) begin
                    r_gsize  <= r_best;
                    r_gstart <= r_best_start;
                end else begin
                    r_gsize  <= r_min[EW-1:OB];
                    r_gstart <= '0;
                end
            end
            OP_OVL: begin
                if (hit && r_prev_d) begin
                    r_ovp <= 1'b1;
                end
                if (hit && !r_prev_d) begin
                    r_ovc <= 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.decide) begin
            r_success <= frame_end || (st == ST_OK);
            r_status  <= st;
            r_offset  <= (!frame_end && (st == ST_OK)) ? 32'(r_b) : 32'd0;
            r_lf      <= 32'(r_gsize);
            r_lfs     <= 32'(r_gstart);
        end
    end

    assign o_count              = NW'(r_prev_cnt) + NW'(r_cur_cnt);
    assign o_stat.out_busy      = r_out_valid && !i_ready;
    assign o_valid              = r_out_valid;
    assign o_success            = r_success;
    assign o_status             = r_status;
    assign o_offset             = r_offset;
    assign o_largest_free       = r_lf;
    assign o_largest_free_start = r_lfs;

endmodule

// File: rtl/frua_ctrl.sv
// ----------------------------------------------------------------------------
// frua_ctrl
// Sequencer that walks the range tables for the gap search and overlap check.
// ----------------------------------------------------------------------------
module frua_ctrl #(
    parameter int MAX_RANGES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic [$clog2(2*MAX_RANGES+1)-1:0] i_count,
    input  frua_pkg::t_stat                   i_stat,
    output frua_pkg::t_cmd                    o_cmd,
    output logic [$clog2(2*MAX_RANGES+1)-1:0] o_idx
);
    import frua_pkg::*;

    localparam int NW = $clog2(2 * MAX_RANGES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CALC, S_GX, S_GY, S_GF, S_GF2, S_GEND, S_OV, S_DRAIN, S_DEC
    } t_state;

    t_state        r_state;
    logic [2:0]    r_cnt;
    logic [NW-1:0] r_ox, r_iy;
    logic [NW-1:0] last;

    assign last        = NW'(i_count - NW'(1));
    assign o_req_ready = r_state == S_IDLE;
    assign o_idx       = (r_state == S_GX) ? r_ox : r_iy;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_req_valid;
        o_cmd.decide = (r_state == S_DEC) && !i_stat.out_busy;
        unique case (r_state)
            S_GX:    o_cmd.op = OP_LATCH_X;
            S_GY:    o_cmd.op = OP_SUCC;
            S_GF:    o_cmd.op = OP_FIN;
            S_GF2:   o_cmd.op = OP_FIN2;
            S_GEND:  o_cmd.op = OP_GAP_DONE;
            S_OV:    o_cmd.op = OP_OVL;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ox    <= '0;
            r_iy    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= S_CALC;
                        r_cnt   <= '0;
                    end
                end
                S_CALC: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        r_ox    <= '0;
                        r_state <= (i_count == '0) ? S_GEND : S_GX;
                    end
                end
                S_GX: begin
                    r_iy    <= '0;
                    r_state <= S_GY;
                end
                S_GY: begin
                    if (r_iy == last) begin
                        r_state <= S_GF;
                    end else begin
                        r_iy <= r_iy + NW'(1);
                    end
                end
                S_GF: begin
                    r_state <= S_GF2;
                end
                S_GF2: begin
                    if (r_ox == last) begin
                        r_state <= S_GEND;
                    end else begin
                        r_ox    <= r_ox + NW'(1);
                        r_state <= S_GX;
                    end
                end
                S_GEND: begin
                    r_iy    <= '0;
                    r_state <= (i_count == '0) ? S_DRAIN : S_OV;
                end
                S_OV: begin
                    if (r_iy == last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_iy <= r_iy + NW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/frame_ring_upload_allocator.sv
// ----------------------------------------------------------------------------
// frame_ring_upload_allocator
// Ring allocator for a staging buffer with per-frame range tables.
// ----------------------------------------------------------------------------
// For each request the gap search reads every live range of the current and
// previous frames together once as a candidate and then scans all of these
// ranges for its successor in sorted order, one table read per cycle,
// followed by one overlap pass. Frame end swaps the two table banks. A result
// waits in an output register while the next request is already being taken.
// There is no clearing pass after reset.
`include "assert_macros.svh"

module frame_ring_upload_allocator #(
    parameter int MAX_RANGES     = 64,
    parameter int OFFSET_BITS    = 32,
    parameter int MIN_ALIGN_LOG2 = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    frua_req_if.sink    i_req,
    frua_rsp_if.source  o_rsp
);
    import frua_pkg::*;

    localparam int NW = $clog2(2 * MAX_RANGES + 1);

    t_cmd          s_cmd;
    t_stat         s_stat;
    logic [NW-1:0] w_idx, w_count;

    frua_ctrl #(
        .MAX_RANGES(MAX_RANGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_count     (w_count),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd),
        .o_idx       (w_idx)
    );

    frua_datapath #(
        .MAX_RANGES    (MAX_RANGES),
        .OFFSET_BITS   (OFFSET_BITS),
        .MIN_ALIGN_LOG2(MIN_ALIGN_LOG2)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_req_type          (i_req.req_type),
        .i_req_size          (i_req.req_size),
        .i_align_log2        (i_req.align_log2),
        .i_cmd               (s_cmd),
        .i_idx               (w_idx),
        .o_count             (w_count),
        .o_stat              (s_stat),
        .o_valid             (o_rsp.valid),
        .i_ready             (o_rsp.ready),
        .o_success           (o_rsp.success),
        .o_status            (o_rsp.status),
        .o_offset            (o_rsp.offset),
        .o_largest_free      (o_rsp.largest_free),
        .o_largest_free_start(o_rsp.largest_free_start)
    );

    `ASSERT_NEVER(a_decide_when_busy, i_clk, i_rst_n, s_cmd.decide && s_stat.out_busy)
    `ASSERT_PROP(a_no_result_after_load, i_clk, i_rst_n, s_cmd.load |=> !s_cmd.decide)
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, 32'(w_count) > 32'(2 * MAX_RANGES))

endmodule
